@@ hdl/utf8_stream_decoder_defines.svh @@
// ----------------------------------------------------------------------------
// utf8_stream_decoder_defines
// Assertion macros for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
`ifndef UTF8_STREAM_DECODER_DEFINES_SVH
`define UTF8_STREAM_DECODER_DEFINES_SVH

`ifndef ASSERT_OFF
`define U8SD_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define U8SD_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define U8SD_ASSERT(lbl, prop, msg)
`define U8SD_ASSERT_RST(lbl, prop, msg)
`endif

`endif

@@ hdl/u8sd_pkg.sv @@
// ----------------------------------------------------------------------------
// u8sd_pkg
// Types, constants and the fresh-byte decode for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package u8sd_pkg;

   localparam int unsigned CP_W    = 21;
   localparam int unsigned Q_DEPTH = 4;
   localparam int unsigned Q_PTR_W = 2;
   localparam int unsigned Q_CNT_W = 3;

   localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;

   typedef struct packed {
      logic [CP_W-1:0] code_point;
      logic            malformed;
      logic            text_end;
      logic            last;
   } result_type;

   typedef struct packed {
      logic            has_result;
      result_type      res;
      logic [1:0]      due;
      logic [CP_W-1:0] partial;
   } fresh_type;

   // byte seen with no sequence pending
   function automatic fresh_type fresh_decode(input logic [7:0] b);
      fresh_type f;
      f.has_result     = 1'b1;
      f.res.code_point = {{(CP_W-8){1'b0}}, b};
      f.res.malformed  = 1'b0;
      f.res.text_end   = 1'b0;
      f.res.last       = 1'b0;
      f.due            = 2'd0;
      f.partial        = '0;
      if (b == 8'h00) begin
         f.res.text_end = 1'b1;
      end else if (b[7] == 1'b0) begin
         f.res.text_end = 1'b0;
      end else if (b[7:5] == 3'b110) begin
         f.has_result = 1'b0;
         f.due        = 2'd1;
         f.partial    = {{(CP_W-5){1'b0}}, b[4:0]};
      end else if (b[7:4] == 4'b1110) begin
         f.has_result = 1'b0;
         f.due        = 2'd2;
         f.partial    = {{(CP_W-4){1'b0}}, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
         f.has_result = 1'b0;
         f.due        = 2'd3;
         f.partial    = {{(CP_W-3){1'b0}}, b[2:0]};
      end else begin
         f.res.code_point = REPLACEMENT_CP;
         f.res.malformed  = 1'b1;
      end
      return f;
   endfunction

endpackage

@@ hdl/utf8_stream_decoder.sv @@
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Decodes a zero-terminated UTF-8 byte stream into code points.
// ----------------------------------------------------------------------------
// One byte per item in, zero to two code point items out per byte. An
// accepted byte is registered, then decoded and its results written to a
// four-entry result queue. The first result is offered once its byte has
// been decoded and written. The decode of a registered byte waits only
// while the queue cannot take two more items. With the result side taking
// an item every cycle, one byte is accepted every cycle as long as each
// byte gives at most one item. The result side moves one item per cycle,
// so a byte that gives two items leaves one item of backlog. The queue
// absorbs that backlog until it reaches four items, after which the input
// stalls. Malformed input gives U+FFFD with malformed set. A broken
// sequence gives U+FFFD followed by the result of the offending byte, if
// it gives one at once; a lead byte there starts a new sequence. The zero
// byte gives a text_end item and leaves the decoder idle for a new text.
`include "utf8_stream_decoder_defines.svh"

module utf8_stream_decoder
   import u8sd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic [7:0]      req_in_byte,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output logic [CP_W-1:0] rsp_code_point,
   output logic            rsp_malformed,
   output logic            rsp_text_end,
   output logic            rsp_last
);

   logic               in_vld_ff, in_vld_in;
   logic [7:0]         in_byte_ff;
   logic [1:0]         due_ff, due_in;
   logic [CP_W-1:0]    pv_ff, pv_in;
   result_type         q_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0] cnt_ff, cnt_in;

   logic               pop, fire, cont;
   logic [Q_CNT_W-1:0] cnt_after_pop;
   logic [1:0]         n_res;
   logic [1:0]         due_dec;
   logic [CP_W-1:0]    ext;
   fresh_type          fr;
   result_type         r0, r1;
   logic [1:0]         dec_due;
   logic [CP_W-1:0]    dec_pv;
   logic               rsp_is_repl;
   logic               rsp_end_ok;

   assign rsp_valid      = (cnt_ff != '0);
   assign pop            = rsp_valid & rsp_ready;
   assign cnt_after_pop  = cnt_ff - {{(Q_CNT_W-1){1'b0}}, pop};
   assign fire           = in_vld_ff && (cnt_after_pop <= Q_CNT_W'(Q_DEPTH - 2));
   assign req_ready      = !in_vld_ff || fire;

   assign rsp_code_point = q_ff[rd_ptr_ff].code_point;
   assign rsp_malformed  = q_ff[rd_ptr_ff].malformed;
   assign rsp_text_end   = q_ff[rd_ptr_ff].text_end;
   assign rsp_last       = q_ff[rd_ptr_ff].last;

   assign rsp_is_repl    = (rsp_code_point == REPLACEMENT_CP);
   assign rsp_end_ok     = rsp_last && !rsp_malformed && (rsp_code_point == '0);

   always_comb begin
      fr      = fresh_decode(in_byte_ff);
      cont    = (in_byte_ff[7:6] == 2'b10);
      ext     = {pv_ff[CP_W-7:0], in_byte_ff[5:0]};
      due_dec = due_ff - 2'd1;
      r0      = fr.res;
      r1      = fr.res;
      n_res   = {1'b0, fr.has_result};
      dec_due = fr.due;
      dec_pv  = fr.partial;
      if (due_ff != 2'd0) begin
         if (cont) begin
            if (due_dec == 2'd0) begin
               n_res   = 2'd1;
               dec_due = 2'd0;
               dec_pv  = '0;
               r0.text_end = 1'b0;
               if (ext == '0) begin
                  r0.code_point = REPLACEMENT_CP;
                  r0.malformed  = 1'b1;
               end else begin
                  r0.code_point = ext;
                  r0.malformed  = 1'b0;
               end
            end else begin
               n_res   = 2'd0;
               dec_due = due_dec;
               dec_pv  = ext;
            end
         end else begin
            r0.code_point = REPLACEMENT_CP;
            r0.malformed  = 1'b1;
            r0.text_end   = 1'b0;
            n_res         = fr.has_result ? 2'd2 : 2'd1;
         end
      end
      r0.last = (n_res == 2'd1);
      r1.last = 1'b1;
   end

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_valid && req_ready) begin
         in_vld_in = 1'b1;
      end else if (fire) begin
         in_vld_in = 1'b0;
      end
      due_in    = fire ? dec_due : due_ff;
      pv_in     = fire ? dec_pv : pv_ff;
      rd_ptr_in = rd_ptr_ff + {{(Q_PTR_W-1){1'b0}}, pop};
      wr_ptr_in = wr_ptr_ff;
      cnt_in    = cnt_after_pop;
      if (fire) begin
         wr_ptr_in = wr_ptr_ff + n_res;
         cnt_in    = cnt_after_pop + {1'b0, n_res};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         due_ff    <= 2'd0;
         pv_ff     <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         in_vld_ff <= in_vld_in;
         due_ff    <= due_in;
         pv_ff     <= pv_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_in_byte;
      end
      if (fire && (n_res != 2'd0)) begin
         q_ff[wr_ptr_ff] <= r0;
      end
      if (fire && (n_res == 2'd2)) begin
         q_ff[wr_ptr_ff + Q_PTR_W'(1)] <= r1;
      end
   end

   `U8SD_ASSERT(a_cnt_bound, cnt_ff <= Q_CNT_W'(Q_DEPTH), "result queue overflow")
   `U8SD_ASSERT(a_mal_repl, rsp_valid && rsp_malformed |-> rsp_is_repl, "malformed not FFFD")
   `U8SD_ASSERT(a_end_last, rsp_valid && rsp_text_end |-> rsp_end_ok, "bad text end item")
   `U8SD_ASSERT_RST(a_rst_empty, $past(reset) |-> cnt_ff == '0 && !in_vld_ff, "busy after reset")

endmodule
